// File: rtl/core/mi4_pkg.sv
// mi4_pkg: shared constants, types and helper functions for the 4x4 adjugate inverse core
// no dependencies; used by every module in rtl/core except mi4_ram
`default_nettype none
package mi4_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int OPA_W     = DATA_W + 1;
	localparam int PROD_W    = OPA_W + DATA_W;
	localparam int ACC_W     = 160;
	localparam int MINOR_W   = 128;
	localparam int DIV_W     = 192;
	localparam int NUM_SHIFT = 2 * FRAC_BITS;
	localparam int DET_SHIFT = 3 * FRAC_BITS;
	localparam int N_ELEM    = 16;
	localparam int IDX_W     = 4;
	localparam int QCNT_W    = 5;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic signed [DATA_W-1:0] elem_t;

	typedef struct packed {
		logic       mul_en;
		logic       acc_en;
		logic       acc_clr;
		logic       acc_sub;
		logic [1:0] acc_sh;
	} mac_ctl_t;

	// column picked by factor n of permutation term (six terms of a 3x3 determinant)
	function automatic logic [1:0] perm_col(input logic [2:0] term, input logic [1:0] n);
		logic [5:0] p;
		begin
			case (term)
				3'd0: p = {2'd2, 2'd1, 2'd0};
				3'd1: p = {2'd1, 2'd2, 2'd0};
				3'd2: p = {2'd2, 2'd0, 2'd1};
				3'd3: p = {2'd0, 2'd2, 2'd1};
				3'd4: p = {2'd1, 2'd0, 2'd2};
				3'd5: p = {2'd0, 2'd1, 2'd2};
				default: p = '0;
			endcase
			case (n)
				2'd0: perm_col = p[1:0];
				2'd1: perm_col = p[3:2];
				default: perm_col = p[5:4];
			endcase
		end
	endfunction

	// odd permutations
	function automatic logic perm_neg(input logic [2:0] term);
		perm_neg = (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
	endfunction

	// n-th index that remains once index del is removed
	function automatic logic [1:0] skip_idx(input logic [1:0] del, input logic [1:0] n);
		skip_idx = (n < del) ? n : n + 2'd1;
	endfunction

	// floor by 2^(3F), saturate to 32 bits
	function automatic elem_t det_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] sh;
		begin
			sh = v >>> DET_SHIFT;
			if ((&sh[ACC_W-1:DATA_W-1]) || !(|sh[ACC_W-1:DATA_W-1]))
				det_sat = sh[DATA_W-1:0];
			else
				det_sat = sh[ACC_W-1] ? SAT_MIN : SAT_MAX;
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/mi4_ram.sv
// mi4_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module mi4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/mi4_mac.sv
// mi4_mac: shared 33x32 signed multiplier with registered product and wide accumulator
// depends on mi4_pkg
`default_nettype none
module mi4_mac (
	input  wire logic                               clk,
	input  wire mi4_pkg::mac_ctl_t                  ctl,
	input  wire logic signed [mi4_pkg::OPA_W-1:0]   opa,
	input  wire logic signed [mi4_pkg::DATA_W-1:0]  opb,
	output logic signed      [mi4_pkg::PROD_W-1:0]  prod,
	output logic signed      [mi4_pkg::ACC_W-1:0]   acc
);
	import mi4_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  addend;

	assign addend = ACC_W'(prod_q) << {ctl.acc_sh, 5'b0};

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= opa * opb;
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= ctl.acc_sub ? acc_q - addend : acc_q + addend;
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule
`default_nettype wire

// File: rtl/core/mi4_div.sv
// mi4_div: radix-2 restoring divider, one quotient bit per cycle, saturated 32-bit result
// depends on mi4_pkg
`default_nettype none
module mi4_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [mi4_pkg::MINOR_W-1:0] minor,
	input  wire logic                               flip,
	input  wire logic signed [mi4_pkg::ACC_W-1:0]   den,
	output logic                                    done,
	output mi4_pkg::elem_t                          quot
);
	import mi4_pkg::*;

	typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_FIN} dstate_t;

	dstate_t             state_q;
	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    dsh_q;
	logic [DATA_W-1:0]   q_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                neg_q;
	logic                ovf_q;
	logic [MINOR_W-1:0]  abs_m;
	logic [ACC_W-1:0]    abs_d;
	logic                ge;

	assign abs_m = minor[MINOR_W-1] ? MINOR_W'(-minor) : MINOR_W'(minor);
	assign abs_d = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
	assign ge    = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) state_q <= D_CHK;
				end
				D_CHK: state_q <= D_RUN;
				D_RUN: begin
					if (cnt_q == '0) state_q <= D_FIN;
				end
				D_FIN: state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					rem_q <= DIV_W'(abs_m) << NUM_SHIFT;
					dsh_q <= DIV_W'(abs_d) << (DATA_W - 1);
					neg_q <= minor[MINOR_W-1] ^ flip ^ den[ACC_W-1];
					q_q   <= '0;
				end
			end
			D_CHK: begin
				ovf_q <= rem_q >= (dsh_q << 1);
				cnt_q <= QCNT_W'(DATA_W - 1);
			end
			D_RUN: begin
				if (ge) rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[DATA_W-2:0], ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (ovf_q)
			quot = neg_q ? SAT_MIN : SAT_MAX;
		else if (neg_q)
			quot = (q_q > SAT_MIN) ? SAT_MIN : -q_q;
		else
			quot = (q_q > SAT_MAX) ? SAT_MAX : q_q;
	end

	assign done = state_q == D_FIN;

endmodule
`default_nettype wire

// File: rtl/core/matrix4_inverse_adjugate_core.sv
// matrix4_inverse_adjugate_core: top level, load sequencer and compute sequencer
// depends on mi4_pkg, mi4_ram, mi4_mac, mi4_div
`default_nettype none
// Loads sixteen Q16.16 elements in row-major order, one transaction per cycle while
// load_stall is low. It then computes all sixteen 3x3 minors with one shared 33x32
// multiplier (six permutation terms per minor, each multiplied out and accumulated in
// turn, then one write of the minor), the determinant from the first-row minors (each
// minor fetched, then multiplied and accumulated as four 32-bit limbs), and each
// inverse element with a restoring divider at one quotient bit per cycle (the divider
// is skipped when singular). load_stall stays high from the last element until the
// final result is taken, output stalls included. Results come out as sixteen
// transactions with last on the final one; singular flags a zero determinant and
// forces the inverse to zero.
module matrix4_inverse_adjugate_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mi4_pkg::elem_t element,
	input  wire logic           load_valid,
	output logic                load_stall,
	output mi4_pkg::elem_t      inv_element,
	output logic [1:0]          row_index,
	output logic [1:0]          col_index,
	output mi4_pkg::elem_t      determinant,
	output logic                singular,
	output logic                last,
	output logic                result_valid,
	input  wire logic           result_stall
);
	import mi4_pkg::*;

	typedef enum logic [4:0] {
		S_LOAD, S_T_A, S_T_B, S_T_MAB, S_T_C, S_T_MLO, S_T_MHI, S_T_AHI, S_T_WR,
		S_D_RD, S_D_CAP, S_D_MUL, S_D_ACC, S_D_FIN,
		S_O_RD, S_O_CAP, S_O_DIV, S_O_SEND
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     load_cnt_q;
	logic [IDX_W-1:0]     mi_q;
	logic [2:0]           term_q;
	logic [1:0]           j_q;
	logic [1:0]           chunk_q;
	logic [IDX_W-1:0]     o_q;
	logic                 valid_q;
	logic                 sing_q;
	elem_t                dq_q;
	elem_t                inv_q;

	elem_t                mat_q [N_ELEM];
	elem_t                a_q;
	elem_t                b_q;
	logic [2*DATA_W-1:0]  p_q;
	logic [MINOR_W-1:0]   m_q;

	logic                 load_acc;
	logic                 res_acc;
	logic [IDX_W-1:0]     rd_addr;
	elem_t                rd_data;
	logic [IDX_W-1:0]     ram_raddr;
	logic [MINOR_W-1:0]   ram_rdata;
	logic                 ram_we;
	mac_ctl_t             ctl;
	logic signed [OPA_W-1:0]  opa;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc;
	logic                 div_start;
	logic                 div_done;
	elem_t                div_quot;
	logic [DATA_W-1:0]    chunk;

	assign load_stall = state_q != S_LOAD;
	assign load_acc   = load_valid && !load_stall;
	assign res_acc    = valid_q && !result_stall;

	always_comb begin
		case (state_q)
			S_T_A: rd_addr = {skip_idx(mi_q[3:2], 2'd0),
				skip_idx(mi_q[1:0], perm_col(term_q, 2'd0))};
			S_T_B: rd_addr = {skip_idx(mi_q[3:2], 2'd1),
				skip_idx(mi_q[1:0], perm_col(term_q, 2'd1))};
			S_T_C: rd_addr = {skip_idx(mi_q[3:2], 2'd2),
				skip_idx(mi_q[1:0], perm_col(term_q, 2'd2))};
			S_D_RD: rd_addr = {2'b00, j_q};
			default: rd_addr = '0;
		endcase
	end
	assign rd_data = mat_q[rd_addr];

	always_comb begin
		case (state_q)
			S_D_RD: ram_raddr = {2'b00, j_q};
			default: ram_raddr = {o_q[1:0], o_q[3:2]};
		endcase
	end
	assign ram_we = state_q == S_T_WR;

	assign chunk = m_q[{chunk_q, 5'b0} +: DATA_W];

	always_comb begin
		ctl = '0;
		opa = '0;
		case (state_q)
			S_LOAD: ctl.acc_clr = 1'b1;
			S_T_MAB: begin
				ctl.mul_en = 1'b1;
				opa = {a_q[DATA_W-1], a_q};
			end
			S_T_MLO: begin
				ctl.mul_en = 1'b1;
				opa = {1'b0, p_q[DATA_W-1:0]};
			end
			S_T_MHI: begin
				ctl.mul_en  = 1'b1;
				opa = {p_q[2*DATA_W-1], p_q[2*DATA_W-1:DATA_W]};
				ctl.acc_en  = 1'b1;
				ctl.acc_sub = perm_neg(term_q);
			end
			S_T_AHI: begin
				ctl.acc_en  = 1'b1;
				ctl.acc_sub = perm_neg(term_q);
				ctl.acc_sh  = 2'd1;
			end
			S_T_WR: ctl.acc_clr = 1'b1;
			S_D_MUL: begin
				ctl.mul_en = 1'b1;
				opa = (chunk_q == 2'd3) ? {chunk[DATA_W-1], chunk} : {1'b0, chunk};
			end
			S_D_ACC: begin
				ctl.acc_en  = 1'b1;
				ctl.acc_sub = j_q[0];
				ctl.acc_sh  = chunk_q;
			end
			default: begin
			end
		endcase
	end

	assign div_start = state_q == S_O_CAP;

	mi4_mac u_mac (
		.clk  (clk),
		.ctl  (ctl),
		.opa  (opa),
		.opb  (b_q),
		.prod (prod),
		.acc  (acc)
	);

	mi4_ram #(.WIDTH(MINOR_W), .DEPTH(N_ELEM)) u_minor_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (mi_q),
		.wdata (acc[MINOR_W-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mi4_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.minor  (ram_rdata),
		.flip   (o_q[2] ^ o_q[0]),
		.den    (acc),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (load_acc) mat_q[load_cnt_q] <= element;
		case (state_q)
			S_T_A: a_q <= rd_data;
			S_T_B: b_q <= rd_data;
			S_T_C: begin
				p_q <= prod[2*DATA_W-1:0];
				b_q <= rd_data;
			end
			S_D_RD: b_q <= rd_data;
			S_D_CAP: m_q <= ram_rdata;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			load_cnt_q <= '0;
			mi_q       <= '0;
			term_q     <= '0;
			j_q        <= '0;
			chunk_q    <= '0;
			o_q        <= '0;
			valid_q    <= 1'b0;
			sing_q     <= 1'b0;
			dq_q       <= '0;
			inv_q      <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (load_acc) begin
						load_cnt_q <= load_cnt_q + 1'b1;
						if (load_cnt_q == IDX_W'(N_ELEM - 1)) begin
							mi_q    <= '0;
							term_q  <= '0;
							state_q <= S_T_A;
						end
					end
				end
				S_T_A: state_q <= S_T_B;
				S_T_B: state_q <= S_T_MAB;
				S_T_MAB: state_q <= S_T_C;
				S_T_C: state_q <= S_T_MLO;
				S_T_MLO: state_q <= S_T_MHI;
				S_T_MHI: state_q <= S_T_AHI;
				S_T_AHI: begin
					if (term_q == 3'd5) begin
						state_q <= S_T_WR;
					end else begin
						term_q  <= term_q + 1'b1;
						state_q <= S_T_A;
					end
				end
				S_T_WR: begin
					term_q <= '0;
					if (mi_q == IDX_W'(N_ELEM - 1)) begin
						j_q     <= '0;
						state_q <= S_D_RD;
					end else begin
						mi_q    <= mi_q + 1'b1;
						state_q <= S_T_A;
					end
				end
				S_D_RD: begin
					chunk_q <= '0;
					state_q <= S_D_CAP;
				end
				S_D_CAP: state_q <= S_D_MUL;
				S_D_MUL: state_q <= S_D_ACC;
				S_D_ACC: begin
					if (chunk_q == 2'd3) begin
						if (j_q == 2'd3) begin
							state_q <= S_D_FIN;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_D_RD;
						end
					end else begin
						chunk_q <= chunk_q + 1'b1;
						state_q <= S_D_MUL;
					end
				end
				S_D_FIN: begin
					sing_q  <= acc == '0;
					dq_q    <= det_sat(acc);
					o_q     <= '0;
					state_q <= S_O_RD;
				end
				S_O_RD: begin
					if (sing_q) begin
						inv_q   <= '0;
						valid_q <= 1'b1;
						state_q <= S_O_SEND;
					end else begin
						state_q <= S_O_CAP;
					end
				end
				S_O_CAP: state_q <= S_O_DIV;
				S_O_DIV: begin
					if (div_done) begin
						inv_q   <= div_quot;
						valid_q <= 1'b1;
						state_q <= S_O_SEND;
					end
				end
				S_O_SEND: begin
					if (res_acc) begin
						valid_q <= 1'b0;
						if (o_q == IDX_W'(N_ELEM - 1)) begin
							state_q <= S_LOAD;
						end else begin
							o_q     <= o_q + 1'b1;
							state_q <= S_O_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign inv_element  = inv_q;
	assign row_index    = o_q[3:2];
	assign col_index    = o_q[1:0];
	assign determinant  = dq_q;
	assign singular     = sing_q;
	assign last         = o_q == IDX_W'(N_ELEM - 1);
	assign result_valid = valid_q;

`ifndef NO_ASSERTIONS
	a_valid_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> state_q == S_O_SEND)
		else $error("result valid outside send state");
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> row_index == 2'd3 && col_index == 2'd3)
		else $error("last not on corner element");
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && singular |-> inv_element == '0 && determinant == '0)
		else $error("singular result not zero");
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && last |=> !load_stall && load_cnt_q == '0)
		else $error("no reload after last transaction");
`endif

endmodule
`default_nettype wire
